@@ design/assert_macros.svh @@
// Assertion shorthands, included by hrff_datapath.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check on every clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check on every clock edge, reset included.
`define ASSERT_CLK_ALL(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ design/hrff_pkg.sv @@
package hrff_pkg;

  localparam int COORD_BITS  = 7;
  localparam int PID_W       = 21;
  localparam int GRID_W      = 8;
  localparam int DPN_W       = 7;
  localparam int AXES        = 3;
  localparam int MOD_STAGES  = 4;
  localparam int COORD_STEPS = GRID_W / MOD_STAGES;
  localparam int NODE_DIV_W  = 24;
  localparam int NODE_STEPS  = NODE_DIV_W / MOD_STAGES;

  typedef enum logic [1:0] {
    REG_GRID_X = 2'd0,
    REG_GRID_Y = 2'd1,
    REG_GRID_Z = 2'd2,
    REG_DPN    = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [AXES-1:0][GRID_W-1:0] grid;
    logic [DPN_W-1:0]            dpn;
  } cfg_t;

  typedef struct packed {
    logic                        vld;
    logic [AXES-1:0][GRID_W-1:0] cu;
    logic [AXES-1:0][GRID_W-1:0] cv;
    logic [AXES-1:0][GRID_W-1:0] ru;
    logic [AXES-1:0][GRID_W-1:0] rv;
    logic [AXES-1:0]             neg;
    logic [NODE_DIV_W-1:0]       dd;
    logic [DPN_W-1:0]            rd;
    logic [PID_W-1:0]            dst;
    logic [AXES-1:0]             hnz;
    logic                        face;
    logic                        bad;
  } div_t;

  typedef struct packed {
    logic                       vld;
    logic [AXES-1:0][PID_W-1:0] cand;
    logic [AXES-1:0]            en;
    logic [PID_W-1:0]           lo;
    logic                       bad;
  } fix_t;

endpackage

@@ design/hrff_datapath.sv @@
module hrff_datapath (
  input  logic                      clk,
  input  logic                      rst,
  input  hrff_pkg::cfg_t            cfg,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [20:0]               src_pid,
  input  logic [20:0]               dest_pid,
  input  logic signed [1:0]         halo_x,
  input  logic signed [1:0]         halo_y,
  input  logic signed [1:0]         halo_z,
  input  logic signed [1:0]         step_sign,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic                      routed,
  output logic [20:0]               via_pid,
  output logic                      src_bad
);
  import hrff_pkg::*;

  `include "assert_macros.svh"

  div_t stg [0:MOD_STAGES];
  div_t s0_next;
  fix_t fx;
  fix_t fx_next;
  logic adv;
  logic             routed_next;
  logic [PID_W-1:0] via_next;

  function automatic logic [GRID_W-1:0] mod_bit(input logic [GRID_W-1:0] r, input logic b,
                                                input logic [GRID_W-1:0] g);
    logic [GRID_W:0] w;
    w = {r, b};
    if (w >= {1'b0, g}) w = w - {1'b0, g};
    return w[GRID_W-1:0];
  endfunction

  function automatic logic [DPN_W-1:0] node_bit(input logic [DPN_W-1:0] r, input logic b,
                                                input logic [DPN_W-1:0] d);
    logic [DPN_W:0] w;
    w = {r, b};
    if (w >= {1'b0, d}) w = w - {1'b0, d};
    return w[DPN_W-1:0];
  endfunction

  function automatic div_t div_step(input div_t s, input cfg_t c);
    div_t n;
    n = s;
    for (int j = 0; j < COORD_STEPS; j++) begin
      for (int a = 0; a < AXES; a++) begin
        n.ru[a] = mod_bit(n.ru[a], n.cu[a][GRID_W-1], c.grid[a]);
        n.cu[a] = {n.cu[a][GRID_W-2:0], 1'b0};
        n.rv[a] = mod_bit(n.rv[a], n.cv[a][GRID_W-1], c.grid[a]);
        n.cv[a] = {n.cv[a][GRID_W-2:0], 1'b0};
      end
    end
    for (int j = 0; j < NODE_STEPS; j++) begin
      n.rd = node_bit(n.rd, n.dd[NODE_DIV_W-1], c.dpn);
      n.dd = {n.dd[NODE_DIV_W-2:0], 1'b0};
    end
    return n;
  endfunction

  function automatic logic [PID_W-1:0] interleave(input logic [AXES-1:0][COORD_BITS-1:0] w);
    logic [PID_W-1:0] p;
    p = '0;
    for (int b = 0; b < COORD_BITS; b++) begin
      for (int a = 0; a < AXES; a++) begin
        p[3*b + (AXES-1-a)] = w[a][b];
      end
    end
    return p;
  endfunction

  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;

  always_comb begin
    logic signed [1:0] h [AXES];
    logic [AXES-1:0][COORD_BITS-1:0] c;
    logic signed [3:0] st;
    logic signed [8:0] t;
    logic [8:0] mag;
    logic [1:0] ah;
    logic [2:0] kind;
    h[0] = halo_x;
    h[1] = halo_y;
    h[2] = halo_z;
    kind = '0;
    s0_next = '0;
    s0_next.vld = in_valid;
    s0_next.dst = dest_pid;
    s0_next.dd  = {{(NODE_DIV_W-PID_W){1'b0}}, dest_pid};
    for (int a = 0; a < AXES; a++) begin
      for (int b = 0; b < COORD_BITS; b++) begin
        c[a][b] = src_pid[3*b + (AXES-1-a)];
      end
      st  = $signed({{2{step_sign[1]}}, step_sign}) * $signed({{2{h[a][1]}}, h[a]});
      t   = $signed({2'b00, c[a]}) + $signed({{5{st[3]}}, st});
      mag = t[8] ? 9'(-t) : 9'(t);
      ah  = h[a][1] ? 2'(~h[a] + 2'd1) : 2'(h[a]);
      kind = kind + {1'b0, ah};
      s0_next.cu[a]  = {1'b0, c[a]};
      s0_next.cv[a]  = mag[GRID_W-1:0];
      s0_next.neg[a] = t[8];
      s0_next.hnz[a] = (h[a] != 2'sd0);
      if ({1'b0, c[a]} >= cfg.grid[a]) s0_next.bad = 1'b1;
    end
    s0_next.face = (kind == 3'd1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i <= MOD_STAGES; i++) stg[i].vld <= 1'b0;
    end else if (adv) begin
      stg[0] <= s0_next;
      for (int i = 0; i < MOD_STAGES; i++) stg[i+1] <= div_step(stg[i], cfg);
    end
  end

  always_comb begin
    logic [AXES-1:0][COORD_BITS-1:0] wu;
    logic [AXES-1:0][COORD_BITS-1:0] wc;
    logic [GRID_W-1:0] r;
    for (int a = 0; a < AXES; a++) begin
      wu[a] = stg[MOD_STAGES].ru[a][COORD_BITS-1:0];
    end
    fx_next.vld = stg[MOD_STAGES].vld;
    fx_next.bad = stg[MOD_STAGES].bad;
    fx_next.en  = stg[MOD_STAGES].hnz & {AXES{~stg[MOD_STAGES].face}};
    fx_next.lo  = stg[MOD_STAGES].dst - {{(PID_W-DPN_W){1'b0}}, stg[MOD_STAGES].rd};
    for (int a = 0; a < AXES; a++) begin
      r = stg[MOD_STAGES].rv[a];
      if (stg[MOD_STAGES].neg[a] && r != '0) r = cfg.grid[a] - r;
      wc = wu;
      wc[a] = r[COORD_BITS-1:0];
      fx_next.cand[a] = interleave(wc);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fx.vld <= 1'b0;
    end else if (adv) begin
      fx <= fx_next;
    end
  end

  always_comb begin
    logic [AXES-1:0] m;
    logic [PID_W-1:0] diff;
    for (int a = 0; a < AXES; a++) begin
      diff = fx.cand[a] - fx.lo;
      m[a] = fx.en[a] && (fx.cand[a] >= fx.lo) &&
             (diff < {{(PID_W-DPN_W){1'b0}}, cfg.dpn});
    end
    routed_next = |m;
    via_next = '0;
    for (int a = AXES-1; a >= 0; a--) begin
      if (m[a]) via_next = fx.cand[a];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= fx.vld;
      routed    <= routed_next;
      via_pid   <= via_next;
      src_bad   <= fx.bad;
    end
  end

  `ASSERT_CLK(a_via_zero, out_valid && !routed |-> via_pid == '0, "via_pid set without route")
  `ASSERT_CLK(a_stall_blocks, out_valid && !out_ready |-> !in_ready, "transfer taken in stall")
  `ASSERT_CLK(a_face_no_route, stg[MOD_STAGES].vld && stg[MOD_STAGES].face && adv |=> fx.en == '0,
              "face halo enabled a candidate")
  `ASSERT_CLK_ALL(a_reset_idle, rst |=> !out_valid && !fx.vld, "pipeline valid after reset")

endmodule

@@ design/halo_reroute_face_finder.sv @@
// A result passes stg[0], the divide stages, fx and the output registers.
// Throughput: one lookup per cycle without stalls; coordinate and node
// remainders run two and six quotient bits per stage through four stages.
// A stall on the result side holds every stage in place.
// Reset: synchronous, active high; clears all valid bits and sets the
// grid and node-size registers to 1.
module halo_reroute_face_finder (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [3:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [20:0]       src_pid,
  input  logic [20:0]       dest_pid,
  input  logic signed [1:0] halo_x,
  input  logic signed [1:0] halo_y,
  input  logic signed [1:0] halo_z,
  input  logic signed [1:0] step_sign,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              routed,
  output logic [20:0]       via_pid,
  output logic              src_bad
);
  import hrff_pkg::*;

  logic [GRID_W-1:0] grid_x;
  logic [GRID_W-1:0] grid_y;
  logic [GRID_W-1:0] grid_z;
  logic [DPN_W-1:0]  node_size;
  logic              wr;
  cfg_t              cfg;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_x    <= GRID_W'(1);
      grid_y    <= GRID_W'(1);
      grid_z    <= GRID_W'(1);
      node_size <= DPN_W'(1);
    end else if (wr) begin
      case (reg_idx_t'(paddr[3:2]))
        REG_GRID_X: grid_x    <= pwdata[GRID_W-1:0];
        REG_GRID_Y: grid_y    <= pwdata[GRID_W-1:0];
        REG_GRID_Z: grid_z    <= pwdata[GRID_W-1:0];
        REG_DPN:    node_size <= pwdata[DPN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx_t'(paddr[3:2]))
      REG_GRID_X: prdata = {{(32-GRID_W){1'b0}}, grid_x};
      REG_GRID_Y: prdata = {{(32-GRID_W){1'b0}}, grid_y};
      REG_GRID_Z: prdata = {{(32-GRID_W){1'b0}}, grid_z};
      REG_DPN:    prdata = {{(32-DPN_W){1'b0}}, node_size};
      default:    prdata = '0;
    endcase
  end

  // Treat zero as one.
  assign cfg.grid[0] = (grid_x == '0) ? GRID_W'(1) : grid_x;
  assign cfg.grid[1] = (grid_y == '0) ? GRID_W'(1) : grid_y;
  assign cfg.grid[2] = (grid_z == '0) ? GRID_W'(1) : grid_z;
  assign cfg.dpn     = (node_size == '0) ? DPN_W'(1) : node_size;

  hrff_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .src_pid   (src_pid),
    .dest_pid  (dest_pid),
    .halo_x    (halo_x),
    .halo_y    (halo_y),
    .halo_z    (halo_z),
    .step_sign (step_sign),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .routed    (routed),
    .via_pid   (via_pid),
    .src_bad   (src_bad)
  );

endmodule
